@@ rtl/mbrtu_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the Modbus RTU frame checker.
// No dependencies; imported by every module of the block.
`default_nettype none

package mbrtu_pkg;

    // Frame sizing
    localparam int DEF_MAX_FRAME_BYTES = 256;
    localparam int MIN_FRAME_BYTES     = 8;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int FBYTES_W = 9;
    localparam int CHECK_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // CRC-16 (reflected) constants
    localparam logic [CHECK_W-1:0] CHECK_INIT = 16'hFFFF;
    localparam logic [CHECK_W-1:0] CHECK_POLY = 16'hA001;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_SHORT  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CHECK  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN_FN = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDRESS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READ_CODE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_CODE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_HIGH_FIRST = 3'd3;

    // Register reset values
    localparam logic [BYTE_W-1:0] RST_SLAVE_ADDRESS    = 8'd1;
    localparam logic [BYTE_W-1:0] RST_READ_CODE        = 8'd3;
    localparam logic [BYTE_W-1:0] RST_WRITE_CODE       = 8'd6;
    localparam logic              RST_CHECK_HIGH_FIRST = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] slave_address;
        logic [BYTE_W-1:0] read_code;
        logic [BYTE_W-1:0] write_code;
        logic              check_high_first;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              end_of_frame;
    } item_t;

    // Fold one byte into the running CRC, least significant bit first
    function automatic logic [CHECK_W-1:0] crc_feed(input logic [CHECK_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0]  data);
        logic [CHECK_W-1:0] c;
        c = crc_in ^ {{(CHECK_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CHECK_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mbrtu_cfg_regs.sv @@
// Configuration register bank of the Modbus RTU frame checker.
// Depends on mbrtu_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module mbrtu_cfg_regs
    import mbrtu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; indexes past the bank are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SLAVE_ADDRESS:    cfg_next.slave_address    = cfg_data;
                REG_READ_CODE:        cfg_next.read_code        = cfg_data;
                REG_WRITE_CODE:       cfg_next.write_code       = cfg_data;
                REG_CHECK_HIGH_FIRST: cfg_next.check_high_first = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address    <= RST_SLAVE_ADDRESS;
            cfg_reg.read_code        <= RST_READ_CODE;
            cfg_reg.write_code       <= RST_WRITE_CODE;
            cfg_reg.check_high_first <= RST_CHECK_HIGH_FIRST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/mbrtu_frame_core.sv @@
// Frame state, CRC update, checks and result register of the Modbus RTU frame checker.
// Depends on mbrtu_pkg for cfg_t, item_t, status codes and crc_feed.
`default_nettype none

module mbrtu_frame_core
    import mbrtu_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfg_t                cfg,
    input  wire logic                item_valid,
    input  wire item_t               item,
    output logic                     item_take,
    output logic                     status_valid,
    input  wire logic                status_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [BYTE_W-1:0]        function_code,
    output logic [FBYTES_W-1:0]      frame_bytes,
    output logic [CHECK_W-1:0]       computed_check
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME_BYTES);

    // Frame state
    logic [CHECK_W-1:0] crc_reg,   crc_next;
    logic [BYTE_W-1:0]  held0_reg, held0_next;
    logic [BYTE_W-1:0]  held1_reg, held1_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               addr_reg,  addr_next;
    logic [BYTE_W-1:0]  code_reg,  code_next;

    // Result register
    logic                status_valid_reg, status_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [BYTE_W-1:0]   function_code_reg;
    logic [FBYTES_W-1:0] frame_bytes_reg;
    logic [CHECK_W-1:0]  computed_check_reg;

    logic               out_free;
    logic               fire;
    logic               last_fire;
    logic [CHECK_W-1:0] crc_fed;
    logic [CNT_W-1:0]   n;
    logic [BYTE_W-1:0]  prev_byte;
    logic [CHECK_W-1:0] received;
    logic [STATUS_W-1:0] status_calc;

    // A non-final byte never needs the result slot
    assign out_free  = !status_valid_reg || !status_stall;
    assign fire      = item_valid && (!item.end_of_frame || out_free);
    assign last_fire = fire && item.end_of_frame;
    assign item_take = fire;

    // Byte leaving the two-byte delay goes into the CRC
    assign crc_fed = (count_reg > CNT_W'(1)) ? crc_feed(crc_reg, held1_reg) : crc_reg;
    assign n       = (count_reg == CNT_MAX) ? CNT_MAX : count_reg + CNT_W'(1);

    // Capture address match on the first byte, function code on the second
    always_comb
    begin
        addr_next = addr_reg;
        code_next = code_reg;
        if (count_reg == '0)
        begin
            addr_next = (item.frame_byte == cfg.slave_address);
            code_next = '0;
        end
        else if (count_reg == CNT_W'(1))
        begin
            code_next = item.frame_byte;
        end
    end

    // Assemble the received check from the last two bytes
    always_comb
    begin
        prev_byte = (count_reg != '0) ? held0_reg : '0;
        if (cfg.check_high_first)
            received = {prev_byte, item.frame_byte};
        else
            received = {item.frame_byte, prev_byte};
    end

    // Checks in priority order
    always_comb
    begin
        if (n < CNT_MIN)
            status_calc = STATUS_TOO_SHORT;
        else if (!addr_next)
            status_calc = STATUS_BAD_ADDR;
        else if (received != crc_fed)
            status_calc = STATUS_BAD_CHECK;
        else if (code_next != cfg.read_code && code_next != cfg.write_code)
            status_calc = STATUS_UNKNOWN_FN;
        else
            status_calc = STATUS_OK;
    end

    // Advance the frame state, or clear it after the final byte
    always_comb
    begin
        crc_next   = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        count_next = count_reg;
        if (fire)
        begin
            if (item.end_of_frame)
            begin
                crc_next   = CHECK_INIT;
                held0_next = '0;
                held1_next = '0;
                count_next = '0;
            end
            else
            begin
                crc_next   = crc_fed;
                held0_next = item.frame_byte;
                held1_next = held0_reg;
                count_next = n;
            end
        end
    end

    // Result slot: load on a final byte, drop once transferred
    always_comb
    begin
        status_valid_next = status_valid_reg;
        if (last_fire)
            status_valid_next = 1'b1;
        else if (!status_stall)
            status_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg          <= CHECK_INIT;
            held0_reg        <= '0;
            held1_reg        <= '0;
            count_reg        <= '0;
            addr_reg         <= 1'b0;
            code_reg         <= '0;
            status_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg          <= crc_next;
            held0_reg        <= held0_next;
            held1_reg        <= held1_next;
            count_reg        <= count_next;
            status_valid_reg <= status_valid_next;
            if (fire)
            begin
                addr_reg <= item.end_of_frame ? 1'b0 : addr_next;
                code_reg <= item.end_of_frame ? '0 : code_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (last_fire)
        begin
            status_reg         <= status_calc;
            function_code_reg  <= code_next;
            frame_bytes_reg    <= FBYTES_W'(n);
            computed_check_reg <= crc_fed;
        end
    end

    assign status_valid   = status_valid_reg;
    assign status         = status_reg;
    assign function_code  = function_code_reg;
    assign frame_bytes    = frame_bytes_reg;
    assign computed_check = computed_check_reg;

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("byte count above frame maximum");

    a_final_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        last_fire |=> status_valid_reg)
        else $error("final byte did not load a result");

    a_final_clears_frame: assert property (@(posedge clk) disable iff (!rst_n)
        last_fire |=> (count_reg == '0 && crc_reg == CHECK_INIT && !addr_reg))
        else $error("frame state not cleared after final byte");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !item.end_of_frame && count_reg != CNT_MAX)
            |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("byte count did not advance");

    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item.end_of_frame && status_valid_reg && status_stall) |-> !item_take)
        else $error("final byte taken while result slot held");
`endif

endmodule

`default_nettype wire

@@ rtl/modbus_rtu_frame_checker.sv @@
// Top level of the Modbus RTU frame checker: input register and block wiring.
// Depends on mbrtu_pkg, mbrtu_cfg_regs and mbrtu_frame_core.
`default_nettype none

// Takes a Modbus RTU frame one byte per transfer, end_of_frame marking the last
// byte, and returns one status transfer per frame. The sustained rate is one
// byte per clock: the CRC-16 byte update is eight bit steps of combinational
// XOR logic between the frame state registers and the result register. A
// status is loaded into the result register when its final byte is taken from
// the input register, and is held while status_stall is high. Bytes that are not
// final flow on even while a status is stalled; a final byte waits in the
// input register until the result register is free. There is no clearing pass
// after reset. Configuration writes are to be made only while no frame is in
// flight; slave_address is sampled on the first byte of a frame, the function
// codes on its last byte.
module modbus_rtu_frame_checker
    import mbrtu_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  byte_valid,
    output logic                       byte_stall,
    input  wire logic [BYTE_W-1:0]     frame_byte,
    input  wire logic                  end_of_frame,
    output logic                       status_valid,
    input  wire logic                  status_stall,
    output logic [STATUS_W-1:0]        status,
    output logic [BYTE_W-1:0]          function_code,
    output logic [FBYTES_W-1:0]        frame_bytes,
    output logic [CHECK_W-1:0]         computed_check
);

    cfg_t  cfg;
    item_t item_reg;
    logic  item_valid_reg, item_valid_next;
    logic  item_take;
    logic  accept;

    mbrtu_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register: refill whenever it is empty or being drained
    assign byte_stall = item_valid_reg && !item_take;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
            item_valid_next = 1'b1;
        else if (item_take)
            item_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    // Hold the byte payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.frame_byte   <= frame_byte;
            item_reg.end_of_frame <= end_of_frame;
        end
    end

    mbrtu_frame_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .item_valid     (item_valid_reg),
        .item           (item_reg),
        .item_take      (item_take),
        .status_valid   (status_valid),
        .status_stall   (status_stall),
        .status         (status),
        .function_code  (function_code),
        .frame_bytes    (frame_bytes),
        .computed_check (computed_check)
    );

endmodule

`default_nettype wire
